@@ rtl/core/block_pool_allocator_core_assert.svh @@
// Assertion macros shared by the block pool allocator RTL.
// Needs nothing else; take it by include inside a module body.
`ifndef BLOCK_POOL_ALLOCATOR_CORE_ASSERT_SVH
`define BLOCK_POOL_ALLOCATOR_CORE_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define BPA_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("block pool allocator invariant violated");

// Antecedent in this cycle implies consequent in the same cycle.
`define BPA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("block pool allocator implication violated");

// Antecedent in this cycle implies consequent in the next cycle.
`define BPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("block pool allocator sequence violated");

`endif

@@ rtl/core/bpa_pkg.sv @@
// Types, codes and constants of the block pool allocator.
// Used by the allocator core; depends on nothing.
package bpa_pkg;

   localparam int IDX_W   = 10;
   localparam int CNT_W   = 11;
   localparam int CHUNK_W = 3;
   localparam int INDEX_SPACE = 1 << IDX_W;

   localparam int CHUNK_BLOCKS_DEFAULT = 256;
   localparam int MAX_CHUNKS_DEFAULT   = 4;

   // action codes
   localparam logic [2:0] ACT_ALLOC   = 3'd0;
   localparam logic [2:0] ACT_RELEASE = 3'd1;
   localparam logic [2:0] ACT_QUERY   = 3'd2;
   localparam logic [2:0] ACT_REWIND  = 3'd3;
   localparam logic [2:0] ACT_CLEAR   = 3'd4;

   // status codes
   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_NO_SPACE   = 2'd1;
   localparam logic [1:0] ST_NOT_HELD   = 2'd2;

   // register word indexes
   localparam logic [0:0] CSR_CHUNK_LIMIT = 1'b0;
   localparam logic [CHUNK_W-1:0] CHUNK_LIMIT_RESET = 3'd4;

   typedef struct packed {
      logic [2:0]       action;
      logic [IDX_W-1:0] block_index;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]   granted_index;
      logic [1:0]         status;
      logic               is_allocated;
      logic [CNT_W-1:0]   live_count;
      logic [CNT_W-1:0]   high_water;
      logic [CHUNK_W-1:0] chunks_open;
   } rsp_type;

endpackage

@@ rtl/core/block_pool_allocator_core.sv @@
// Block pool allocator: hands out fixed-size block indices from a LIFO free
// stack, falling back to a bump index that opens chunks of CHUNK_BLOCKS up to
// the chunk_limit register (capped at MAX_CHUNKS). A request first reads the
// free stack top and the allocated mark of the addressed block, then updates
// state and writes the memories back once the output register can take the
// response. A new request is taken as soon as the previous one has been processed, even while
// its response still waits in the output register. Neither memory needs a
// clearing pass after reset or clear: a mark is only looked at below the bump
// index, and every such entry has been written since the bump index last
// returned to zero.
module block_pool_allocator_core #(
   parameter int CHUNK_BLOCKS = bpa_pkg::CHUNK_BLOCKS_DEFAULT,
   parameter int MAX_CHUNKS   = bpa_pkg::MAX_CHUNKS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bpa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bpa_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

`include "block_pool_allocator_core_assert.svh"

   localparam int IdxW   = bpa_pkg::IDX_W;
   localparam int CntW   = bpa_pkg::CNT_W;
   localparam int ChunkW = bpa_pkg::CHUNK_W;
   localparam int CapW   = $clog2(CHUNK_BLOCKS) + ChunkW;
   localparam int CmpW   = (CapW > CntW) ? CapW : CntW;
   localparam logic [8:0] MaxChunksV = 9'(MAX_CHUNKS);

   // control and state registers
   logic              busy_ff, busy_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ChunkW-1:0] chunk_limit_ff, chunk_limit_in;
   logic [CntW-1:0]   depth_ff, depth_in;
   logic [CntW-1:0]   bump_ff, bump_in;
   logic [CntW-1:0]   peak_ff, peak_in;
   logic [CntW-1:0]   live_ff, live_in;
   logic [ChunkW-1:0] chunks_ff, chunks_in;

   // payload registers
   bpa_pkg::req_type  req_ff;
   bpa_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   logic              accept;
   logic              exec;
   logic              csr_we;

   logic [IdxW-1:0]   stack_rd_addr;
   logic [CntW-1:0]   depth_dec;
   logic [IdxW-1:0]   stack_rd;
   logic              stack_we;
   logic [IdxW-1:0]   stack_wr_addr;
   logic [0:0]        mark_rd;
   logic              mark_we;
   logic [IdxW-1:0]   mark_wr_addr;
   logic [0:0]        mark_wr_data;

   logic              held;
   logic [ChunkW-1:0] limit;
   logic [CmpW-1:0]   capacity;
   logic [CntW-1:0]   bump_inc;

   assign accept    = req_valid && req_ready;
   assign req_ready = !busy_ff;
   assign exec      = busy_ff && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // configuration port
   assign pready = 1'b1;
   assign csr_we = psel && penable && pwrite && pready;
   always_comb begin
      prdata = '0;
      if (paddr[2:2] == bpa_pkg::CSR_CHUNK_LIMIT) begin
         prdata = {{(32-ChunkW){1'b0}}, chunk_limit_ff};
      end
   end
   assign chunk_limit_in = (csr_we && paddr[2:2] == bpa_pkg::CSR_CHUNK_LIMIT)
                           ? pwdata[ChunkW-1:0] : chunk_limit_ff;

   // read the stack top and the addressed mark while accepting
   assign depth_dec     = depth_ff - CntW'(1);
   assign stack_rd_addr = depth_dec[IdxW-1:0];

   bpa_ram #(.WIDTH(IdxW), .DEPTH(bpa_pkg::INDEX_SPACE)) u_stack (
      .clock   (clock),
      .wr_en   (stack_we),
      .wr_addr (stack_wr_addr),
      .wr_data (req_ff.block_index),
      .rd_en   (accept),
      .rd_addr (stack_rd_addr),
      .rd_data (stack_rd)
   );

   bpa_ram #(.WIDTH(1), .DEPTH(bpa_pkg::INDEX_SPACE)) u_marks (
      .clock   (clock),
      .wr_en   (mark_we),
      .wr_addr (mark_wr_addr),
      .wr_data (mark_wr_data),
      .rd_en   (accept),
      .rd_addr (req_data.block_index),
      .rd_data (mark_rd)
   );

   // no accept during the update cycle, so reads never race a write-back
   assign held     = ({1'b0, req_ff.block_index} < bump_ff) && mark_rd[0];
   assign limit    = ({6'd0, chunk_limit_ff} > MaxChunksV) ? MaxChunksV[ChunkW-1:0]
                                                           : chunk_limit_ff;
   assign capacity = CmpW'(chunks_ff) * CmpW'(CHUNK_BLOCKS);
   assign bump_inc = bump_ff + CntW'(1);

   always_comb begin
      depth_in      = depth_ff;
      bump_in       = bump_ff;
      peak_in       = peak_ff;
      live_in       = live_ff;
      chunks_in     = chunks_ff;
      stack_we      = 1'b0;
      stack_wr_addr = depth_ff[IdxW-1:0];
      mark_we       = 1'b0;
      mark_wr_addr  = req_ff.block_index;
      mark_wr_data  = 1'b0;
      rsp_data_in   = '0;

      if (exec) begin
         unique case (req_ff.action)
            bpa_pkg::ACT_ALLOC: begin
               if (depth_ff != '0) begin
                  depth_in     = depth_dec;
                  rsp_data_in.granted_index = stack_rd;
                  mark_we      = 1'b1;
                  mark_wr_addr = stack_rd;
                  mark_wr_data = 1'b1;
                  live_in      = live_ff + CntW'(1);
               end else if (!bump_ff[IdxW] &&
                            (CmpW'(bump_ff) < capacity || chunks_ff < limit)) begin
                  // open a chunk when the bump index has reached capacity
                  if (CmpW'(bump_ff) >= capacity) begin
                     chunks_in = chunks_ff + ChunkW'(1);
                  end
                  rsp_data_in.granted_index = bump_ff[IdxW-1:0];
                  bump_in      = bump_inc;
                  if (bump_inc > peak_ff) begin
                     peak_in = bump_inc;
                  end
                  mark_we      = 1'b1;
                  mark_wr_addr = bump_ff[IdxW-1:0];
                  mark_wr_data = 1'b1;
                  live_in      = live_ff + CntW'(1);
               end else begin
                  rsp_data_in.status = bpa_pkg::ST_NO_SPACE;
               end
            end
            bpa_pkg::ACT_RELEASE: begin
               if (!held) begin
                  rsp_data_in.status = bpa_pkg::ST_NOT_HELD;
               end else begin
                  if (!depth_ff[IdxW]) begin
                     stack_we = 1'b1;
                     depth_in = depth_ff + CntW'(1);
                  end
                  mark_we = 1'b1;
                  if (live_ff != '0) begin
                     live_in = live_ff - CntW'(1);
                  end
               end
            end
            bpa_pkg::ACT_QUERY: begin
               rsp_data_in.is_allocated = held;
            end
            bpa_pkg::ACT_REWIND: begin
               depth_in = '0;
               bump_in  = '0;
               live_in  = '0;
            end
            bpa_pkg::ACT_CLEAR: begin
               depth_in  = '0;
               bump_in   = '0;
               live_in   = '0;
               peak_in   = '0;
               chunks_in = '0;
            end
            default: begin
            end
         endcase
      end

      rsp_data_in.live_count  = live_in;
      rsp_data_in.high_water  = peak_in;
      rsp_data_in.chunks_open = chunks_in;
   end

   assign busy_in      = accept ? 1'b1 : (exec ? 1'b0 : busy_ff);
   assign rsp_valid_in = exec ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         chunk_limit_ff <= bpa_pkg::CHUNK_LIMIT_RESET;
         depth_ff       <= '0;
         bump_ff        <= '0;
         peak_ff        <= '0;
         live_ff        <= '0;
         chunks_ff      <= '0;
      end else begin
         busy_ff        <= busy_in;
         rsp_valid_ff   <= rsp_valid_in;
         chunk_limit_ff <= chunk_limit_in;
         depth_ff       <= depth_in;
         bump_ff        <= bump_in;
         peak_ff        <= peak_in;
         live_ff        <= live_in;
         chunks_ff      <= chunks_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (exec) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // every index below the bump pointer is either live or on the free stack
   `BPA_ASSERT_ALWAYS(a_conservation, clock, reset, (12'(depth_ff) + 12'(live_ff)) == 12'(bump_ff))
   `BPA_ASSERT_ALWAYS(a_peak_covers_bump, clock, reset, bump_ff <= peak_ff)
   `BPA_ASSERT_ALWAYS(a_bump_in_chunks, clock, reset, CmpW'(bump_ff) <= capacity)
   `BPA_ASSERT_IMPLY(a_fail_grants_zero, clock, reset, rsp_valid_ff && rsp_data_ff.status == bpa_pkg::ST_NO_SPACE, rsp_data_ff.granted_index == '0)
   `BPA_ASSERT_NEXT(a_update_completes, clock, reset, busy_ff && !rsp_valid_ff, rsp_valid_ff && !busy_ff)

endmodule

@@ rtl/core/bpa_ram.sv @@
// Simple dual-port synchronous RAM with registered read data.
// One write and one read port per cycle; depends on nothing.
module bpa_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
